// File: sv/detection_box_decode_clip_defines.svh
// assertion helpers shared by the block's modules
`ifndef DETECTION_BOX_DECODE_CLIP_DEFINES_SVH
`define DETECTION_BOX_DECODE_CLIP_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define DBDC_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// implication checked in the same cycle
`define DBDC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: sv/dbdc_pkg.sv
`default_nettype none
package dbdc_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int WIDE_W      = 48;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 17;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_CONF_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 2'd2;

	localparam logic [16:0] CONF_THRESHOLD_RST = 17'd32768;
	localparam logic [13:0] FRAME_WIDTH_RST    = 14'd640;
	localparam logic [13:0] FRAME_HEIGHT_RST   = 14'd640;

	// 1.5 in Q15.16
	localparam logic signed [31:0] NORM_LIMIT = 32'sd98304;

	typedef struct packed {
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] box_w;
		logic signed [31:0] box_h;
		logic [16:0]        confidence;
	} det_in_t;

	typedef struct packed {
		logic [29:0] out_left;
		logic [29:0] out_top;
		logic [29:0] out_width;
		logic [29:0] out_height;
		logic [16:0] out_confidence;
	} det_out_t;

	typedef struct packed {
		logic [16:0] conf_threshold;
		logic [13:0] frame_width;
		logic [13:0] frame_height;
	} cfg_t;

	// detection that passed the confidence check, with its scaling class
	typedef struct packed {
		det_in_t det;
		logic    norm;
	} det_item_t;

	// scale a normalized coordinate to pixels, or widen a pixel coordinate
	function automatic logic signed [WIDE_W-1:0] scale_q16(
		input logic signed [31:0] v,
		input logic [13:0]        f,
		input logic               norm
	);
		logic signed [46:0] prod;
		prod = v * $signed({1'b0, f});
		if (norm) begin
			return WIDE_W'(prod);
		end
		return WIDE_W'(v);
	endfunction

endpackage
`default_nettype wire

// File: sv/detection_box_decode_clip.sv
// throughput: one detection per cycle while out_stall is low; front register,
// 4-entry queue, 3 back stages and an output register each advance independently
// detections below the confidence threshold or with an empty clipped box give no result
// reset: asynchronous active low; clears all valid flags and the queue, and loads
// threshold 0.5, frame 640 x 640
`default_nettype none
module detection_box_decode_clip
	import dbdc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire det_in_t               in_data,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output det_out_t                   out_data
);

	cfg_t      cfg_q;
	logic      push_valid, push_stall;
	det_item_t push_item;
	logic      pop_valid, pop_stall;
	det_item_t pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.conf_threshold <= CONF_THRESHOLD_RST;
			cfg_q.frame_width    <= FRAME_WIDTH_RST;
			cfg_q.frame_height   <= FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CONF_THRESHOLD: cfg_q.conf_threshold <= cfg_data;
				REG_FRAME_WIDTH:    cfg_q.frame_width    <= cfg_data[13:0];
				REG_FRAME_HEIGHT:   cfg_q.frame_height   <= cfg_data[13:0];
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

	dbdc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_item  (push_item)
	);

	dbdc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_stall  (pop_stall),
		.pop_item   (pop_item)
	);

	dbdc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.pop_valid (pop_valid),
		.pop_stall (pop_stall),
		.pop_item  (pop_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// File: sv/dbdc_front.sv
`default_nettype none
`include "detection_box_decode_clip_defines.svh"
module dbdc_front
	import dbdc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_t      cfg,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire det_in_t   in_data,
	output logic           push_valid,
	input  wire logic      push_stall,
	output det_item_t      push_item
);

	logic      valid_s1;
	det_item_t item_s1;
	logic      keep;
	logic      norm;

	assign in_stall = valid_s1 && push_stall;

	// low-confidence detections are consumed here and never reach the queue
	assign keep = in_data.confidence >= cfg.conf_threshold;
	assign norm = (in_data.center_x <= NORM_LIMIT) && (in_data.center_y <= NORM_LIMIT) &&
		(in_data.box_w <= NORM_LIMIT) && (in_data.box_h <= NORM_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			item_s1.det  <= in_data;
			item_s1.norm <= norm;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

	`DBDC_ASSERT_IMPL(a_front_conf_kept, valid_s1, item_s1.det.confidence >= cfg.conf_threshold, "front holds a detection below threshold")

endmodule
`default_nettype wire

// File: sv/dbdc_queue.sv
`default_nettype none
`include "detection_box_decode_clip_defines.svh"
module dbdc_queue
	import dbdc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push_valid,
	output logic           push_stall,
	input  wire det_item_t push_item,
	output logic           pop_valid,
	input  wire logic      pop_stall,
	output det_item_t      pop_item
);

	det_item_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign push_stall = count_q == QCNT_W'(QUEUE_DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && !push_stall;
	assign do_pop     = pop_valid && !pop_stall;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	`DBDC_ASSERT_ALWAYS(a_queue_no_overflow, count_q <= QCNT_W'(QUEUE_DEPTH), "queue count above depth")
	`DBDC_ASSERT_ALWAYS(a_queue_ptr_match, QPTR_W'(wr_ptr_q - rd_ptr_q) == count_q[QPTR_W-1:0], "queue pointers disagree with count")

endmodule
`default_nettype wire

// File: sv/dbdc_back.sv
`default_nettype none
`include "detection_box_decode_clip_defines.svh"
module dbdc_back
	import dbdc_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_t      cfg,
	input  wire logic      pop_valid,
	output logic           pop_stall,
	input  wire det_item_t pop_item,
	output logic           out_valid,
	input  wire logic      out_stall,
	output det_out_t       out_data
);

	// s2: scaled box
	logic                     valid_s2;
	logic signed [WIDE_W-1:0] x_s2, y_s2, w_s2, h_s2;
	logic [16:0]              conf_s2;
	// s3: corner form
	logic                     valid_s3;
	logic signed [WIDE_W-1:0] left_s3, top_s3, w_s3, h_s3;
	logic [16:0]              conf_s3;
	// s4: clipped at the low edge
	logic                     valid_s4;
	logic signed [WIDE_W-1:0] left_s4, top_s4, w_s4, h_s4;
	logic [16:0]              conf_s4;

	logic     out_valid_q;
	det_out_t out_data_q;

	logic adv_out, adv4, adv3, adv2;

	logic signed [WIDE_W-1:0] lim_x, lim_y;
	logic signed [WIDE_W-1:0] left_n, top_n;
	logic signed [WIDE_W-1:0] left4_n, top4_n, w4_n, h4_n;
	logic signed [WIDE_W-1:0] w_fin, h_fin;
	logic                     keep3, keep_out;

	assign adv_out   = !out_valid_q || !out_stall;
	assign adv4      = !valid_s4 || adv_out;
	assign adv3      = !valid_s3 || adv4;
	assign adv2      = !valid_s2 || adv3;
	assign pop_stall = !adv2;

	assign lim_x = $signed(WIDE_W'({cfg.frame_width, FRAC_BITS'(0)}));
	assign lim_y = $signed(WIDE_W'({cfg.frame_height, FRAC_BITS'(0)}));

	always_comb begin
		keep3  = (w_s2 > 0) && (h_s2 > 0);
		left_n = x_s2 - (w_s2 >>> 1);
		top_n  = y_s2 - (h_s2 >>> 1);
	end

	// low edge: a negative corner shortens the box
	always_comb begin
		left4_n = left_s3;
		w4_n    = w_s3;
		if (left_s3 < 0) begin
			left4_n = '0;
			w4_n    = w_s3 + left_s3;
		end
		top4_n = top_s3;
		h4_n   = h_s3;
		if (top_s3 < 0) begin
			top4_n = '0;
			h4_n   = h_s3 + top_s3;
		end
	end

	// high edge
	always_comb begin
		w_fin = w_s4;
		if (left_s4 + w_s4 > lim_x) begin
			w_fin = lim_x - left_s4;
		end
		h_fin = h_s4;
		if (top_s4 + h_s4 > lim_y) begin
			h_fin = lim_y - top_s4;
		end
		keep_out = (w_fin > 0) && (h_fin > 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv2) begin
				valid_s2 <= pop_valid;
			end
			if (adv3) begin
				valid_s3 <= valid_s2 && keep3;
			end
			if (adv4) begin
				valid_s4 <= valid_s3;
			end
			if (adv_out) begin
				out_valid_q <= valid_s4 && keep_out;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			x_s2    <= scale_q16(pop_item.det.center_x, cfg.frame_width, pop_item.norm);
			y_s2    <= scale_q16(pop_item.det.center_y, cfg.frame_height, pop_item.norm);
			w_s2    <= scale_q16(pop_item.det.box_w, cfg.frame_width, pop_item.norm);
			h_s2    <= scale_q16(pop_item.det.box_h, cfg.frame_height, pop_item.norm);
			conf_s2 <= pop_item.det.confidence;
		end
		if (adv3) begin
			left_s3 <= left_n;
			top_s3  <= top_n;
			w_s3    <= w_s2;
			h_s3    <= h_s2;
			conf_s3 <= conf_s2;
		end
		if (adv4) begin
			left_s4 <= left4_n;
			top_s4  <= top4_n;
			w_s4    <= w4_n;
			h_s4    <= h4_n;
			conf_s4 <= conf_s3;
		end
		if (adv_out) begin
			out_data_q.out_left       <= left_s4[29:0];
			out_data_q.out_top        <= top_s4[29:0];
			out_data_q.out_width      <= w_fin[29:0];
			out_data_q.out_height     <= h_fin[29:0];
			out_data_q.out_confidence <= conf_s4;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`DBDC_ASSERT_IMPL(a_back_size_positive, out_valid_q, (out_data_q.out_width != '0) && (out_data_q.out_height != '0), "result with empty size")
	`DBDC_ASSERT_IMPL(a_back_inside_frame, out_valid_q, WIDE_W'(out_data_q.out_left) + WIDE_W'(out_data_q.out_width) <= lim_x, "result extends past frame width")

endmodule
`default_nettype wire

// File: tb/sv/tb_detection_box_decode_clip.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_detection_box_decode_clip
	import dbdc_pkg::*;
();

	localparam int unsigned Q1 = 65536;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned SETTLE_CYCLES = 16;
	localparam int unsigned PHASES = 8;
	localparam int unsigned PHASE_ITEMS = 80;

	typedef enum logic [1:0] {ROW_PREDICT, ROW_DROPPED, ROW_KEPT} row_kind_t;

	typedef struct {
		det_in_t   det;
		row_kind_t kind;
		det_out_t  box;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	det_in_t in_data;
	logic out_valid;
	logic out_stall;
	det_out_t out_data;

	// local copy of the register file
	logic [16:0] thr_q;
	logic [13:0] frame_w_q;
	logic [13:0] frame_h_q;

	det_out_t clipped_box_q[$];
	dir_row_t dir_rows[$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned send_pct = 0;
	int unsigned recv_pct = 0;

	int unsigned phase_thr [PHASES] = '{0, 65536, 32768, 131071, 20000, 1, 45000, 32768};
	int unsigned phase_fw [PHASES] = '{1, 8192, 1920, 640, 0, 16383, 320, 640};
	int unsigned phase_fh [PHASES] = '{1, 8192, 1080, 480, 480, 16383, 0, 640};
	int unsigned mode_send [4] = '{0, 70, 0, 31};
	int unsigned mode_recv [4] = '{0, 0, 70, 31};

	detection_box_decode_clip u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always #2 clk = ~clk;

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("%0t ERROR %s", $time, what);
	endtask

	// trims one axis to [0, limit]; false when nothing is left
	function automatic bit clip_span(inout longint pos, inout longint len, input longint limit);
		if (pos < 0) begin
			len = len + pos;
			pos = 0;
		end
		if (pos + len > limit)
			len = limit - pos;
		return len > 0;
	endfunction

	function automatic bit decode_clip_box(input det_in_t d, output det_out_t r);
		longint cx, cy, bw, bh, left, top, fw, fh;
		r = '0;
		cx = longint'($signed(d.center_x));
		cy = longint'($signed(d.center_y));
		bw = longint'($signed(d.box_w));
		bh = longint'($signed(d.box_h));
		fw = longint'(frame_w_q);
		fh = longint'(frame_h_q);
		if (d.confidence < thr_q)
			return 1'b0;
		// all four at most 1.5 means normalized coordinates
		if (cx <= NORM_LIMIT && cy <= NORM_LIMIT && bw <= NORM_LIMIT && bh <= NORM_LIMIT) begin
			cx = cx * fw;
			cy = cy * fh;
			bw = bw * fw;
			bh = bh * fh;
		end
		if (bw <= 0 || bh <= 0)
			return 1'b0;
		left = cx - (bw >>> 1);
		top = cy - (bh >>> 1);
		if (!clip_span(left, bw, fw <<< FRAC_BITS))
			return 1'b0;
		if (!clip_span(top, bh, fh <<< FRAC_BITS))
			return 1'b0;
		r.out_left = 30'(left);
		r.out_top = 30'(top);
		r.out_width = 30'(bw);
		r.out_height = 30'(bh);
		r.out_confidence = d.confidence;
		return 1'b1;
	endfunction

	function automatic void add_row(input logic signed [31:0] cx, cy, bw, bh,
			input logic [16:0] conf, input row_kind_t kind,
			input logic [29:0] l = '0, t = '0, rw = '0, rh = '0);
		dir_row_t row;
		row.det = '{center_x: cx, center_y: cy, box_w: bw, box_h: bh, confidence: conf};
		row.kind = kind;
		row.box = '{out_left: l, out_top: t, out_width: rw, out_height: rh,
			out_confidence: conf};
		dir_rows.insert(dir_rows.size(), row);
	endfunction

	function automatic logic [31:0] boundary_q16();
		case ($urandom_range(7))
			0: return 32'd98303;
			1: return 32'd98304;
			2: return 32'd98305;
			3: return 32'd0;
			4: return 32'hFFFFFFFF;
			5: return 32'd1;
			6: return 32'h7FFFFFFF;
			default: return 32'h80000000;
		endcase
	endfunction

	function automatic det_in_t make_detection();
		det_in_t d;
		int unsigned fw_px, fh_px, pick;
		fw_px = (frame_w_q == 0) ? 64 : frame_w_q;
		fh_px = (frame_h_q == 0) ? 64 : frame_h_q;
		pick = $urandom_range(99);
		if (pick < 45) begin
			// normalized, partly off frame, sizes occasionally not positive
			d.center_x = $urandom_range(85196) - 13107;
			d.center_y = $urandom_range(85196) - 13107;
			d.box_w = $urandom_range(98304 + 8000) - 8000;
			d.box_h = $urandom_range(98304 + 8000) - 8000;
		end else if (pick < 80) begin
			d.center_x = $urandom_range((fw_px + 200) * Q1) - 100 * Q1;
			d.center_y = $urandom_range((fh_px + 200) * Q1) - 100 * Q1;
			d.box_w = $urandom_range(fw_px * Q1) - Q1 / 2;
			d.box_h = $urandom_range(fh_px * Q1) - Q1 / 2;
		end else if (pick < 90) begin
			d.center_x = boundary_q16();
			d.center_y = boundary_q16();
			d.box_w = boundary_q16();
			d.box_h = boundary_q16();
		end else begin
			d.center_x = $urandom();
			d.center_y = $urandom();
			d.box_w = $urandom();
			d.box_h = $urandom();
		end
		pick = $urandom_range(9);
		if (pick < 8)
			d.confidence = 17'($urandom_range(131071, thr_q));
		else if (pick == 8 && thr_q != 0)
			d.confidence = 17'($urandom_range(thr_q - 1, 0));
		else
			d.confidence = 17'($urandom_range(131071));
		return d;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_CONF_THRESHOLD: thr_q = val;
			REG_FRAME_WIDTH: frame_w_q = val[13:0];
			REG_FRAME_HEIGHT: frame_h_q = val[13:0];
			default: ;
		endcase
	endtask

	task automatic send_detection(input det_in_t d, input row_kind_t kind, input det_out_t box);
		det_out_t want;
		if (send_pct != 0) begin
			while ($urandom_range(99) < send_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data <= d;
		do
			@(posedge clk);
		while (in_stall);
		// transfer taken at this edge
		case (kind)
			ROW_KEPT: clipped_box_q.insert(clipped_box_q.size(), box);
			ROW_DROPPED: ;
			default: if (decode_clip_box(d, want)) clipped_box_q.insert(clipped_box_q.size(), want);
		endcase
	endtask

	task automatic wait_idle();
		while (clipped_box_q.size() != 0)
			@(posedge clk);
		// dropped detections may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin : result_check
		det_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (clipped_box_q.size() == 0) begin
				report_mismatch("result with no detection waiting");
			end else begin
				want = clipped_box_q.pop_front();
				if (out_data.out_left !== want.out_left || out_data.out_top !== want.out_top
						|| out_data.out_width !== want.out_width
						|| out_data.out_height !== want.out_height
						|| out_data.out_confidence !== want.out_confidence)
					report_mismatch($sformatf(
						"box got l=%h t=%h w=%h h=%h c=%h, expected l=%h t=%h w=%h h=%h c=%h",
						out_data.out_left, out_data.out_top, out_data.out_width,
						out_data.out_height, out_data.out_confidence, want.out_left,
						want.out_top, want.out_width, want.out_height, want.out_confidence));
			end
		end
		out_stall <= (recv_pct != 0) && ($urandom_range(99) < recv_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		in_data <= '0;
		out_stall <= 1'b0;
		thr_q = 17'd32768;
		frame_w_q = 14'd640;
		frame_h_q = 14'd640;

		// reset settings: threshold 0.5, frame 640 x 640
		add_row(300 * Q1, 300 * Q1, 40 * Q1, 40 * Q1, 17'd32767, ROW_DROPPED);
		add_row(630 * Q1, 630 * Q1, 40 * Q1, 40 * Q1, 17'd32768, ROW_KEPT,
			30'd39976960, 30'd39976960, 30'd1966080, 30'd1966080);
		add_row(32768, 32768, 65536, 65536, 17'd65536, ROW_KEPT,
			30'd0, 30'd0, 30'd41943040, 30'd41943040);
		add_row(100 * Q1, 200 * Q1, 40 * Q1, 20 * Q1, 17'd131071, ROW_KEPT,
			30'd5242880, 30'd12451840, 30'd2621440, 30'd1310720);
		add_row(0, 0, 100 * Q1, 100 * Q1, 17'd40000, ROW_KEPT,
			30'd0, 30'd0, 30'd3276800, 30'd3276800);
		add_row(32768, 32768, 0, 65536, 17'd65536, ROW_DROPPED);
		add_row(32768, 32768, 65536, -65536, 17'd65536, ROW_DROPPED);
		add_row(2000 * Q1, 100 * Q1, 10 * Q1, 10 * Q1, 17'd65536, ROW_DROPPED);
		add_row(100 * Q1, 2000 * Q1, 10 * Q1, 10 * Q1, 17'd65536, ROW_DROPPED);
		add_row(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 17'h1FFFF,
			ROW_PREDICT);
		add_row(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000, 17'h1FFFF,
			ROW_DROPPED);
		// exactly 1.5 everywhere still counts as normalized
		add_row(98304, 98304, 98304, 98304, 17'd50000, ROW_KEPT,
			30'd31457280, 30'd31457280, 30'd10485760, 30'd10485760);
		add_row(98305, 98304, 98304, 98304, 17'd50000, ROW_PREDICT);
		// odd raw sizes, half truncates
		add_row(300 * Q1, 300 * Q1, 3, 5, 17'd50000, ROW_PREDICT);
		add_row(-10 * Q1, 50 * Q1, 30 * Q1, 20 * Q1, 17'd50000, ROW_PREDICT);
		add_row(0, 0, 0, 0, 17'd65536, ROW_DROPPED);
		add_row(320 * Q1, 320 * Q1, 640 * Q1, 640 * Q1, 17'd65535, ROW_KEPT,
			30'd0, 30'd0, 30'd41943040, 30'd41943040);
		add_row(645 * Q1, 300 * Q1, 10 * Q1, 10 * Q1, 17'd65536, ROW_DROPPED);

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_detection(dir_rows[i].det, dir_rows[i].kind, dir_rows[i].box);

		for (int p = 0; p < PHASES; p++) begin
			in_valid <= 1'b0;
			wait_idle();
			write_reg(REG_CONF_THRESHOLD, CFG_DATA_W'(phase_thr[p]));
			write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(phase_fw[p]));
			write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(phase_fh[p]));
			cfg_we <= 1'b0;
			send_pct = mode_send[p % 4];
			recv_pct = mode_recv[p % 4];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// hold off mid-phase until the pipeline has emptied
				if (n == PHASE_ITEMS / 2) begin
					in_valid <= 1'b0;
					wait_idle();
				end
				send_detection(make_detection(), ROW_PREDICT, '0);
			end
		end
		in_valid <= 1'b0;
		wait_idle();

		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire

// File: files.f
+incdir+sv
sv/dbdc_pkg.sv
sv/dbdc_front.sv
sv/dbdc_queue.sv
sv/dbdc_back.sv
sv/detection_box_decode_clip.sv
tb/sv/tb_detection_box_decode_clip.sv
